[hw/rtl/afc_pkg.sv]
// shared types and constants for the six-plane box culling unit
`timescale 1ns / 1ps

package afc_pkg;

	// plane set held in configuration
	localparam int NUM_PLANES = 6;
	localparam int PLANE_W    = 64;
	localparam int CFG_IDX_W  = $clog2(NUM_PLANES);

	// fixed point formats: Q1.14 normals, integer offset scaled to Q.14
	localparam int NORM_W    = 16;
	localparam int OFF_W     = 16;
	localparam int OFF_SHIFT = 14;

	// object id width
	localparam int ID_W = 32;

	// beat kinds carried in tuser
	localparam logic OP_TEST  = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	// classification codes on the result beat
	typedef enum logic [1:0] {
		CLS_OUTSIDE   = 2'd0,
		CLS_INSIDE    = 2'd1,
		CLS_INTERSECT = 2'd2
	} cull_class_t;

	// one plane register: nx in the low bits, then ny, nz, offset on top
	typedef struct packed {
		logic [OFF_W-1:0]       d;
		logic [2:0][NORM_W-1:0] n;
	} plane_t;

endpackage

[hw/rtl/aabb_frustum_cull_unit.sv]
// six-plane frustum test of axis-aligned boxes with saturating statistics
//
// channel   direction  fields (lowest bit first)
// --------  ---------  ----------------------------------------------------------
// s_*       in         tuser: opcode; tdata: object_id, min_x, min_y, min_z,
//                      max_x, max_y, max_z
// m_*       out        tdata: result_id, cull_class, is_visible, submitted_total,
//                      visible_total, culled_total
// cfg_*     in         write: index 0..5 = left, right, bottom, top, near, far
//
// one beat per cycle sustained while m_tready is high, each beat passing the stages in order:
// stage 1 multiplies the chosen corners by the normals, stage 2 adds pairs,
// stage 3 takes the distance signs, the output register classifies and counts
// each stage holds its own valid bit and loads when empty or when the next one
// moves, so bubbles close up and a stall on m_tready loses nothing
// reset clears the valid bits, the counters and the planes (all boxes inside)
`timescale 1ns / 1ps

module aabb_frustum_cull_unit
	import afc_pkg::*;
#(
	parameter int COORD_BITS = 16,
	parameter int COUNT_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,

	// input beats
	input  logic s_tvalid,
	output logic s_tready,
	input  logic s_tuser,  // opcode
	// object_id, min_x, min_y, min_z, max_x, max_y, max_z
	input  logic [((ID_W + 6*COORD_BITS + 7) / 8) * 8 - 1:0] s_tdata,

	// result beats
	output logic m_tvalid,
	input  logic m_tready,
	// result_id, cull_class, is_visible, submitted_total, visible_total, culled_total
	output logic [((ID_W + 3 + 3*COUNT_BITS + 7) / 8) * 8 - 1:0] m_tdata,

	// plane configuration writes
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [PLANE_W-1:0]   cfg_data
);

	localparam int OUT_W        = ID_W + 3 + 3*COUNT_BITS;
	localparam int OUT_TDATA_W  = ((OUT_W + 7) / 8) * 8;
	localparam int PROD_W       = NORM_W + COORD_BITS;
	localparam int OFF_SCALED_W = OFF_W + OFF_SHIFT;
	localparam int SUM_W        = ((PROD_W > OFF_SCALED_W) ? PROD_W : OFF_SCALED_W) + 2;

	// plane registers
	plane_t planes_q [NUM_PLANES];

	// stage enables, back to front
	logic en_s1, en_s2, en_s3, en_out;

	// stage 1: corner products, corner 0 is the far corner along the normal
	logic                     v_s1;
	logic                     op_s1;
	logic [ID_W-1:0]          id_s1;
	logic signed [PROD_W-1:0] prod_s1 [NUM_PLANES][2][3];
	logic signed [PROD_W-1:0] prod_d  [NUM_PLANES][2][3];

	// stage 2: partial sums
	logic                    v_s2;
	logic                    op_s2;
	logic [ID_W-1:0]         id_s2;
	logic signed [SUM_W-1:0] sxy_s2 [NUM_PLANES][2];
	logic signed [SUM_W-1:0] szd_s2 [NUM_PLANES][2];

	// stage 3: plane verdicts
	logic            v_s3;
	logic            op_s3;
	logic [ID_W-1:0] id_s3;
	logic            outside_s3;
	logic            straddle_s3;
	logic            outside_d;
	logic            straddle_d;

	// output register and counters
	logic                  out_valid_q;
	logic [ID_W-1:0]       out_id_q;
	cull_class_t           out_class_q;
	logic                  out_vis_q;
	logic [COUNT_BITS-1:0] submitted_q;
	logic [COUNT_BITS-1:0] visible_q;
	logic [COUNT_BITS-1:0] culled_q;
	cull_class_t           cls_d;

	// handshake chain
	assign en_out   = !out_valid_q || m_tready;
	assign en_s3    = !v_s3 || en_out;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign s_tready = en_s1;

	// configuration writes, indexes past the plane set are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_PLANES; k++) begin
				planes_q[k] <= '0;
			end
		end else if (cfg_we && (cfg_index < CFG_IDX_W'(NUM_PLANES))) begin
			planes_q[cfg_index] <= plane_t'(cfg_data);
		end
	end

	// corner choice from the normal sign and the products
	always_comb begin
		logic signed [NORM_W-1:0]     nrm;
		logic signed [COORD_BITS-1:0] lo;
		logic signed [COORD_BITS-1:0] hi;
		for (int k = 0; k < NUM_PLANES; k++) begin
			for (int a = 0; a < 3; a++) begin
				nrm = $signed(planes_q[k].n[a]);
				lo  = $signed(s_tdata[ID_W + a*COORD_BITS +: COORD_BITS]);
				hi  = $signed(s_tdata[ID_W + (3 + a)*COORD_BITS +: COORD_BITS]);
				if (nrm[NORM_W-1]) begin
					prod_d[k][0][a] = PROD_W'(nrm) * PROD_W'(lo);
					prod_d[k][1][a] = PROD_W'(nrm) * PROD_W'(hi);
				end else begin
					prod_d[k][0][a] = PROD_W'(nrm) * PROD_W'(hi);
					prod_d[k][1][a] = PROD_W'(nrm) * PROD_W'(lo);
				end
			end
		end
	end

	// stage 1 registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			op_s1   <= s_tuser;
			id_s1   <= s_tdata[ID_W-1:0];
			prod_s1 <= prod_d;
		end
	end

	// stage 2: x plus y, and z plus the scaled offset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			op_s2 <= op_s1;
			id_s2 <= id_s1;
			for (int k = 0; k < NUM_PLANES; k++) begin
				for (int c = 0; c < 2; c++) begin
					sxy_s2[k][c] <= SUM_W'(prod_s1[k][c][0]) + SUM_W'(prod_s1[k][c][1]);
					szd_s2[k][c] <= SUM_W'(prod_s1[k][c][2])
						+ (SUM_W'($signed(planes_q[k].d)) <<< OFF_SHIFT);
				end
			end
		end
	end

	// distance signs folded over the planes
	always_comb begin
		logic signed [SUM_W-1:0] dist_far;
		logic signed [SUM_W-1:0] dist_near;
		outside_d  = 1'b0;
		straddle_d = 1'b0;
		for (int k = 0; k < NUM_PLANES; k++) begin
			dist_far   = sxy_s2[k][0] + szd_s2[k][0];
			dist_near  = sxy_s2[k][1] + szd_s2[k][1];
			outside_d  = outside_d  | dist_far[SUM_W-1];
			straddle_d = straddle_d | dist_near[SUM_W-1];
		end
	end

	// stage 3 registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			op_s3       <= op_s2;
			id_s3       <= id_s2;
			outside_s3  <= outside_d;
			straddle_s3 <= straddle_d;
		end
	end

	// classification
	always_comb begin
		if (op_s3 == OP_CLEAR || outside_s3) begin
			cls_d = CLS_OUTSIDE;
		end else if (straddle_s3) begin
			cls_d = CLS_INTERSECT;
		end else begin
			cls_d = CLS_INSIDE;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en_out) begin
			out_valid_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out) begin
			out_id_q    <= id_s3;
			out_class_q <= cls_d;
			out_vis_q   <= (cls_d != CLS_OUTSIDE);
		end
	end

	// saturating statistics, updated as a result beat is loaded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			submitted_q <= '0;
			visible_q   <= '0;
			culled_q    <= '0;
		end else if (en_out && v_s3) begin
			if (op_s3 == OP_CLEAR) begin
				submitted_q <= '0;
				visible_q   <= '0;
				culled_q    <= '0;
			end else begin
				submitted_q <= (&submitted_q) ? submitted_q : submitted_q + COUNT_BITS'(1);
				if (cls_d != CLS_OUTSIDE) begin
					visible_q <= (&visible_q) ? visible_q : visible_q + COUNT_BITS'(1);
				end else begin
					culled_q <= (&culled_q) ? culled_q : culled_q + COUNT_BITS'(1);
				end
			end
		end
	end

	// result beat
	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_TDATA_W'({culled_q, visible_q, submitted_q,
		out_vis_q, out_class_q, out_id_q});

endmodule

[hw/rtl/afc_checker.sv]
// port-level checks on the culling unit result stream, bound to the top level
`timescale 1ns / 1ps

module afc_checker
	import afc_pkg::*;
#(
	parameter int COUNT_BITS = 32
) (
	input logic clk,
	input logic arst_n,
	input logic m_tvalid,
	input logic m_tready,
	input logic [((ID_W + 3 + 3*COUNT_BITS + 7) / 8) * 8 - 1:0] m_tdata
);

	localparam int CLS_LSB = ID_W;
	localparam int VIS_BIT = ID_W + 2;
	localparam int SUB_LSB = ID_W + 3;
	localparam int VSB_LSB = SUB_LSB + COUNT_BITS;
	localparam int CUL_LSB = VSB_LSB + COUNT_BITS;

	logic [1:0]            cls;
	logic                  vis;
	logic [COUNT_BITS-1:0] sub_tot;
	logic [COUNT_BITS-1:0] vis_tot;
	logic [COUNT_BITS-1:0] cul_tot;
	logic [COUNT_BITS:0]   sum_tot;

	// result beat fields
	assign cls     = m_tdata[CLS_LSB +: 2];
	assign vis     = m_tdata[VIS_BIT];
	assign sub_tot = m_tdata[SUB_LSB +: COUNT_BITS];
	assign vis_tot = m_tdata[VSB_LSB +: COUNT_BITS];
	assign cul_tot = m_tdata[CUL_LSB +: COUNT_BITS];
	assign sum_tot = {1'b0, vis_tot} + {1'b0, cul_tot};

	// a stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed under stall");

	// visible flag follows the class
	a_vis: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (vis == (cls != CLS_OUTSIDE)))
		else $error("visible flag disagrees with class");

	// every tested box is either visible or culled until the totals saturate
	a_balance: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !(&sub_tot) |-> (sum_tot == {1'b0, sub_tot}))
		else $error("visible and culled totals do not add up");

	// a visible box has been counted
	a_vis_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (cls == CLS_INSIDE || cls == CLS_INTERSECT) |-> (vis_tot != '0))
		else $error("visible box left visible total at zero");

endmodule

bind aabb_frustum_cull_unit afc_checker #(
	.COUNT_BITS(COUNT_BITS)
) u_afc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
